// ----- rtl/bcf_pkg.sv -----
// shared types and constants of the constant folder
`default_nettype none
package bcf_pkg;

  localparam int unsigned NumVregsDefault = 256;
  localparam int unsigned NumSlotsDefault = 64;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned RegW   = 8;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned DataW  = 64;
  localparam int unsigned OpW    = 4;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD_IMM   = 3'd0,
    MODE_LOAD_LOCAL = 3'd1,
    MODE_STORE      = 3'd2,
    MODE_BINARY     = 3'd3,
    MODE_UNARY      = 3'd4,
    MODE_CALL       = 3'd5,
    MODE_OTHER      = 3'd6,
    MODE_SPARE      = 3'd7
  } mode_e;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_MOD = 4'd4, OP_EQ  = 4'd5, OP_NE  = 4'd6, OP_LT  = 4'd7,
    OP_LE  = 4'd8, OP_GT  = 4'd9, OP_GE  = 4'd10, OP_AND = 4'd11,
    OP_OR  = 4'd12, OP_NEG = 4'd13, OP_NOT = 4'd14, OP_NONE = 4'd15
  } op_e;

  // one request as carried on the channels
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             block_start;
    logic [RegW-1:0]  dest_reg;
    logic [RegW-1:0]  src_a;
    logic [RegW-1:0]  src_b;
    logic [SlotW-1:0] slot;
    logic [DataW-1:0] imm;
    logic [OpW-1:0]   op;
  } instr_t;

  typedef struct packed {
    logic             rewritten;
    logic [RegW-1:0]  out_dest;
    logic [DataW-1:0] folded_value;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/bcf_if.sv -----
// valid/ready channel interfaces for requests and results
`default_nettype none
interface bcf_instr_if;
  logic                      valid;
  logic                      ready;
  logic [bcf_pkg::ModeW-1:0] mode;
  logic                      block_start;
  logic [bcf_pkg::RegW-1:0]  dest_reg;
  logic [bcf_pkg::RegW-1:0]  src_a;
  logic [bcf_pkg::RegW-1:0]  src_b;
  logic [bcf_pkg::SlotW-1:0] slot;
  logic [bcf_pkg::DataW-1:0] imm;
  logic [bcf_pkg::OpW-1:0]   op;
  modport source (output valid, mode, block_start, dest_reg, src_a, src_b, slot, imm, op,
                  input ready);
  modport sink (input valid, mode, block_start, dest_reg, src_a, src_b, slot, imm, op,
                output ready);
endinterface

interface bcf_result_if;
  logic                      valid;
  logic                      ready;
  logic                      rewritten;
  logic [bcf_pkg::RegW-1:0]  out_dest;
  logic [bcf_pkg::DataW-1:0] folded_value;
  modport source (output valid, rewritten, out_dest, folded_value, input ready);
  modport sink (input valid, rewritten, out_dest, folded_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/bcf_front.sv -----
// front end: request capture and two-entry queue to the back end
`default_nettype none
module bcf_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  bcf_instr_if.sink            in_if,
  output bcf_pkg::instr_t      q_data_o,
  output logic                 q_valid_o,
  input  wire logic            q_pop_i
);

  bcf_pkg::instr_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_data_o    = mem_q[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{mode: in_if.mode, block_start: in_if.block_start,
                       dest_reg: in_if.dest_reg, src_a: in_if.src_a, src_b: in_if.src_b,
                       slot: in_if.slot, imm: in_if.imm, op: in_if.op};
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bcf_divider.sv -----
// iterative signed 64-bit divider, one quotient bit a cycle
`default_nettype none
module bcf_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [bcf_pkg::DataW-1:0] a_i,
  input  wire logic [bcf_pkg::DataW-1:0] b_i,
  output logic                           done_o,
  output logic [bcf_pkg::DataW-1:0]      quot_o,
  output logic [bcf_pkg::DataW-1:0]      rem_o
);

  localparam int unsigned W  = bcf_pkg::DataW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_q, r_q, d_q;
  logic          nq_q, nr_q, busy_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    trial;
  logic [W-1:0]  ua, ub;

  assign ua    = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign ub    = b_i[W-1] ? (~b_i + 1'b1) : b_i;
  assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};

  // done stays high with the result until the next start
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = nq_q ? (~q_q + 1'b1) : q_q;
  assign rem_o  = nr_q ? (~r_q + 1'b1) : r_q;

  // restoring shift-subtract step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= ua;
      r_q <= '0;
      d_q <= ub;
      nq_q <= a_i[W-1] ^ b_i[W-1];
      nr_q <= a_i[W-1];
    end else if (busy_q && cnt_q != '0) begin
      if (!trial[W]) begin
        r_q <= trial[W-1:0];
        q_q <= {q_q[W-2:0], 1'b1};
      end else begin
        r_q <= {r_q[W-2:0], q_q[W-1]};
        q_q <= {q_q[W-2:0], 1'b0};
      end
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bcf_back.sv -----
// back end: constant tables, folding and result register
`default_nettype none
module bcf_back #(
  parameter int unsigned NumVregs = bcf_pkg::NumVregsDefault,
  parameter int unsigned NumSlots = bcf_pkg::NumSlotsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bcf_pkg::instr_t q_data_i,
  input  wire logic            q_valid_i,
  output logic                 q_pop_o,
  bcf_result_if.source         out_if
);

  localparam int unsigned W  = bcf_pkg::DataW;
  localparam int unsigned VW = (NumVregs > 1) ? $clog2(NumVregs) : 1;
  localparam int unsigned SW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DIV  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [W-1:0] reg_mem  [NumVregs];
  logic [W-1:0] slot_mem [NumSlots];
  logic [NumVregs-1:0] reg_known_q;
  logic [NumSlots-1:0] slot_known_q;

  bcf_pkg::instr_t ins_q;
  logic [W-1:0] a_q, b_q, s_q, mul_q;
  logic         ka_q, kb_q, ks_q;

  logic         va, vb, vd, vs;
  logic [VW-1:0] ia, ib, id;
  logic [SW-1:0] is;

  // index range checks
  assign va = {24'd0, ins_q.src_a}    < NumVregs;
  assign vb = {24'd0, ins_q.src_b}    < NumVregs;
  assign vd = {24'd0, ins_q.dest_reg} < NumVregs;
  assign vs = {26'd0, ins_q.slot}     < NumSlots;
  assign ia = VW'(ins_q.src_a);
  assign ib = VW'(ins_q.src_b);
  assign id = VW'(ins_q.dest_reg);
  assign is = SW'(ins_q.slot);

  // registered table reads
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      a_q <= reg_mem[ia];
      b_q <= reg_mem[ib];
      s_q <= slot_mem[is];
      ka_q <= va && !ins_q.block_start && reg_known_q[ia];
      kb_q <= vb && !ins_q.block_start && reg_known_q[ib];
      ks_q <= vs && !ins_q.block_start && slot_known_q[is];
    end
  end

  // low 64 bits of the product from three 32x32 partial products
  logic [1:0]   mul_step_q;
  logic [31:0]  mul_x, mul_y;
  logic [W-1:0] mul_p;
  logic         mul_done;

  always_comb begin
    case (mul_step_q)
      2'd0: begin
        mul_x = a_q[31:0];
        mul_y = b_q[31:0];
      end
      2'd1: begin
        mul_x = a_q[31:0];
        mul_y = b_q[63:32];
      end
      default: begin
        mul_x = a_q[63:32];
        mul_y = b_q[31:0];
      end
    endcase
  end

  assign mul_p    = {32'd0, mul_x} * {32'd0, mul_y};
  assign mul_done = (mul_step_q == 2'd3);

  // partial product accumulation
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      case (mul_step_q)
        2'd0: mul_q <= mul_p;
        2'd1, 2'd2: mul_q <= mul_q + {mul_p[31:0], 32'd0};
        default: ;
      endcase
    end
  end

  // multiply step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_step_q <= 2'd0;
    else if (state_q != ST_MUL) mul_step_q <= 2'd0;
    else if (!mul_done) mul_step_q <= mul_step_q + 2'd1;
  end

  // divider
  logic         div_start, div_done;
  logic [W-1:0] quot, rem;
  bcf_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .a_i(a_q), .b_i(b_q), .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  // fold decision
  logic         hit, wr_reg, wr_slot, need_mul, need_div;
  logic [W-1:0] res;
  logic         lt, eq, minov;
  assign lt    = $signed(a_q) < $signed(b_q);
  assign eq    = a_q == b_q;
  assign minov = (a_q == {1'b1, {(W-1){1'b0}}}) && (b_q == '1);

  always_comb begin
    hit      = 1'b0;
    res      = '0;
    wr_reg   = 1'b0;
    wr_slot  = 1'b0;
    need_mul = 1'b0;
    need_div = 1'b0;
    case (ins_q.mode)
      bcf_pkg::MODE_LOAD_IMM: begin
        wr_reg = 1'b1;
        res    = ins_q.imm;
      end
      bcf_pkg::MODE_LOAD_LOCAL: begin
        wr_reg = 1'b1;
        hit    = ks_q;
        res    = ks_q ? s_q : '0;
      end
      bcf_pkg::MODE_STORE: wr_slot = 1'b1;
      bcf_pkg::MODE_BINARY: begin
        wr_reg = 1'b1;
        if (ka_q && kb_q) begin
          hit = 1'b1;
          case (ins_q.op)
            bcf_pkg::OP_ADD: res = a_q + b_q;
            bcf_pkg::OP_SUB: res = a_q - b_q;
            bcf_pkg::OP_MUL: begin
              res = mul_q;
              need_mul = 1'b1;
            end
            bcf_pkg::OP_DIV, bcf_pkg::OP_MOD: begin
              if (b_q == '0) hit = 1'b0;
              else if (minov) res = (ins_q.op == bcf_pkg::OP_DIV) ? a_q : '0;
              else begin
                need_div = 1'b1;
                res = (ins_q.op == bcf_pkg::OP_DIV) ? quot : rem;
              end
            end
            bcf_pkg::OP_EQ:  res = W'(eq);
            bcf_pkg::OP_NE:  res = W'(!eq);
            bcf_pkg::OP_LT:  res = W'(lt);
            bcf_pkg::OP_LE:  res = W'(lt || eq);
            bcf_pkg::OP_GT:  res = W'(!lt && !eq);
            bcf_pkg::OP_GE:  res = W'(!lt);
            bcf_pkg::OP_AND: res = W'((a_q != '0) && (b_q != '0));
            bcf_pkg::OP_OR:  res = W'((a_q != '0) || (b_q != '0));
            default: hit = 1'b0;
          endcase
        end
      end
      bcf_pkg::MODE_UNARY: begin
        wr_reg = 1'b1;
        if (ka_q && ins_q.op == bcf_pkg::OP_NEG) begin
          hit = 1'b1;
          res = '0 - a_q;
        end else if (ka_q && ins_q.op == bcf_pkg::OP_NOT) begin
          hit = 1'b1;
          res = W'(a_q == '0);
        end
      end
      bcf_pkg::MODE_CALL: wr_reg = 1'b1;
      default: ;
    endcase
  end

  logic out_free, fin;
  assign out_free  = !out_if.valid || out_if.ready;
  assign div_start = (state_q == ST_EXEC) && need_div;
  assign fin = out_free && (((state_q == ST_EXEC) && !need_mul && !need_div) ||
                            (state_q == ST_MUL && mul_done) ||
                            (state_q == ST_DIV && div_done));
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (need_div) state_d = ST_DIV;
        else if (need_mul) state_d = ST_MUL;
        else if (fin) state_d = ST_IDLE;
      end
      ST_MUL: if (fin) state_d = ST_IDLE;
      ST_DIV: if (fin) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // table write-back at completion
  always_ff @(posedge clk_i) begin
    if (fin && wr_reg && vd && (hit || ins_q.mode == bcf_pkg::MODE_LOAD_IMM))
      reg_mem[id] <= res;
    if (fin && wr_slot && vs) slot_mem[is] <= a_q;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) ins_q <= q_data_i;
  end

  // control, known bits and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      reg_known_q  <= '0;
      slot_known_q <= '0;
      out_if.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_READ && ins_q.block_start) begin
        reg_known_q  <= '0;
        slot_known_q <= '0;
      end
      if (fin) begin
        if (wr_reg && vd)
          reg_known_q[id] <= hit || (ins_q.mode == bcf_pkg::MODE_LOAD_IMM);
        if (wr_slot && vs) slot_known_q[is] <= ka_q;
        out_if.valid <= 1'b1;
      end else if (out_if.ready) begin
        out_if.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_if.rewritten    <= hit;
      out_if.out_dest     <= hit ? ins_q.dest_reg : '0;
      out_if.folded_value <= hit ? res : '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/block_constant_folder_core.sv -----
// top level of the constant propagation and folding block
//
// Requests arrive on in_if (valid/ready); each gives one result on out_if
// telling whether the instruction is rewritten as a load-immediate.
// The front end queues up to two requests; the back end works on one at a
// time through a sequencer: queue pop, table read, execute and write-back.
// An ordinary request goes from pop through table read and execute to the
// result register; a mul fold adds a multiply state (three 32x32 partial
// products), and a foldable div or mod waits on the one-bit-a-cycle divider.
// The back end pops a new request only once the previous one is done.
// Known bits live in flip-flops cleared at reset and by block start; value
// tables are memories that need no clearing.
// Reset clears the queue, known bits and result valid. When the receiver
// stalls the result is held; the back end waits and the queue then fills,
// after which in_if.ready drops.
`default_nettype none
module block_constant_folder_core #(
  parameter int unsigned NumVregs = bcf_pkg::NumVregsDefault,
  parameter int unsigned NumSlots = bcf_pkg::NumSlotsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bcf_instr_if.sink    in_if,
  bcf_result_if.source out_if
);

  bcf_pkg::instr_t q_data;
  logic            q_valid, q_pop;

  bcf_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if),
    .q_data_o(q_data), .q_valid_o(q_valid), .q_pop_i(q_pop)
  );

  bcf_back #(.NumVregs(NumVregs), .NumSlots(NumSlots)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_data_i(q_data), .q_valid_i(q_valid),
    .q_pop_o(q_pop), .out_if(out_if)
  );

  // a pop needs a queued request
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // no rewrite leaves a zero payload
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.rewritten) |-> (out_if.folded_value == '0 &&
      out_if.out_dest == '0)) else $error("nonzero payload without rewrite");

  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.folded_value)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
